@@ rtl/qrs_pkg.sv @@
// qrs_pkg: widths, status codes and beat types of the quadratic root solver
// no dependencies; used by every module of the block
package qrs_pkg;

  localparam int CoefW = 16;            // coefficient width
  localparam int DiscW = 2*CoefW + 2;   // discriminant width
  localparam int SqrtW = CoefW + 1;     // square root width
  localparam int RemW  = SqrtW + 2;     // square root remainder width
  localparam int MagW  = CoefW + 2;     // numerator magnitude width
  localparam int DenW  = CoefW + 1;     // divisor width, 2|a|
  localparam int QuoW  = MagW + 16;     // dividend and quotient width
  localparam int RootW = 32;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_DOUBLE = 2'd1,
    ST_TWO    = 2'd2,
    ST_AZERO  = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [CoefW-1:0] coef_a;
    logic signed [CoefW-1:0] coef_b;
    logic signed [CoefW-1:0] coef_c;
  } coef_t;

  typedef struct packed {
    logic signed [RootW-1:0] root_plus;
    logic signed [RootW-1:0] root_minus;
    status_e                 root_status;
    logic                    saturated;
  } root_t;

  // side data that travels down the cell rows with each beat
  typedef struct packed {
    logic signed [CoefW-1:0] b;
    logic                    neg_a;
    logic [DenW-1:0]         den;
    status_e                 status;
    logic                    sgn_p;
    logic                    sgn_m;
  } tag_t;

endpackage

@@ rtl/qrs_sqrt_cell.sv @@
// qrs_sqrt_cell: one digit of the floored square root, registered
// depends on qrs_pkg
module qrs_sqrt_cell import qrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  tag_t             tag_i,
  input  logic [DiscW-1:0] rad_i,
  input  logic [RemW-1:0]  rem_i,
  input  logic [SqrtW-1:0] root_i,
  output logic             valid_o,
  output tag_t             tag_o,
  output logic [DiscW-1:0] rad_o,
  output logic [RemW-1:0]  rem_o,
  output logic [SqrtW-1:0] root_o
);

  logic [RemW+2:0]  trial;
  logic [RemW-1:0]  rem_d;
  logic [SqrtW-1:0] root_d;

  always_comb begin
    trial = {1'b0, rem_i, rad_i[DiscW-1 -: 2]} - {3'b000, root_i, 2'b01};
    if (!trial[RemW+2]) begin
      rem_d  = trial[RemW-1:0];
      root_d = {root_i[SqrtW-2:0], 1'b1};
    end else begin
      rem_d  = {rem_i[RemW-3:0], rad_i[DiscW-1 -: 2]};
      root_d = {root_i[SqrtW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_o  <= tag_i;
    rad_o  <= {rad_i[DiscW-3:0], 2'b00};
    rem_o  <= rem_d;
    root_o <= root_d;
  end

endmodule

@@ rtl/qrs_div_cell.sv @@
// qrs_div_cell: one quotient bit of both roots, restoring division, registered
// depends on qrs_pkg
module qrs_div_cell import qrs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  tag_t            tag_i,
  input  logic [QuoW-1:0] dvd_p_i,
  input  logic [QuoW-1:0] dvd_m_i,
  input  logic [DenW-1:0] rem_p_i,
  input  logic [DenW-1:0] rem_m_i,
  input  logic [QuoW-1:0] quo_p_i,
  input  logic [QuoW-1:0] quo_m_i,
  output logic            valid_o,
  output tag_t            tag_o,
  output logic [QuoW-1:0] dvd_p_o,
  output logic [QuoW-1:0] dvd_m_o,
  output logic [DenW-1:0] rem_p_o,
  output logic [DenW-1:0] rem_m_o,
  output logic [QuoW-1:0] quo_p_o,
  output logic [QuoW-1:0] quo_m_o
);

  logic [DenW:0]   part_p, part_m, diff_p, diff_m;
  logic            ge_p, ge_m;

  always_comb begin
    part_p = {rem_p_i, dvd_p_i[QuoW-1]};
    part_m = {rem_m_i, dvd_m_i[QuoW-1]};
    ge_p   = part_p >= {1'b0, tag_i.den};
    ge_m   = part_m >= {1'b0, tag_i.den};
    diff_p = part_p - {1'b0, tag_i.den};
    diff_m = part_m - {1'b0, tag_i.den};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_o   <= tag_i;
    dvd_p_o <= {dvd_p_i[QuoW-2:0], 1'b0};
    dvd_m_o <= {dvd_m_i[QuoW-2:0], 1'b0};
    rem_p_o <= ge_p ? diff_p[DenW-1:0] : part_p[DenW-1:0];
    rem_m_o <= ge_m ? diff_m[DenW-1:0] : part_m[DenW-1:0];
    quo_p_o <= {quo_p_i[QuoW-2:0], ge_p};
    quo_m_o <= {quo_m_i[QuoW-2:0], ge_m};
  end

endmodule

@@ rtl/quadratic_root_solver.sv @@
// Quadratic root solver: one coefficient triple a, b, c (signed Q8.8) per beat in,
// one result (roots in signed Q16.16, status, saturation flag) per beat out.
// A new triple is taken every cycle; busy_o stays low. Each result passes the
// product and discriminant registers, one cell per square root bit (17), the
// numerator register, one division cell per quotient bit (34) and the
// saturation output register. Results come out in order, each
// marked by done_o for one cycle, and cannot be held off.
// depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell
module quadratic_root_solver import qrs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  input  coef_t coef_i,
  output logic  done_o,
  output root_t result_o
);

  localparam int Latency = 4 + SqrtW + QuoW;
  localparam logic [QuoW-1:0] QNegMax = QuoW'(64'h8000_0000);
  localparam logic [QuoW-1:0] QPosMax = QuoW'(64'h7fff_ffff);

  function automatic logic [RootW:0] sat_root(input logic [QuoW-1:0] q, input logic neg);
    logic [RootW-1:0] v;
    logic             s;
    v = '0;
    s = 1'b0;
    if (neg) begin
      s = q > QNegMax;
      v = s ? 32'h8000_0000 : (~q[RootW-1:0] + 1'b1);
    end else begin
      s = q > QPosMax;
      v = s ? 32'h7fff_ffff : q[RootW-1:0];
    end
    return {s, v};
  endfunction

  assign busy_o = 1'b0;

  // products
  logic [CoefW-1:0]   a_mag, b_mag, c_mag;
  logic               v0_q;
  logic [2*CoefW-1:0] b2_q, ac_q;
  logic signed [CoefW-1:0] b0_q;
  logic               neg_a0_q, ac_pos0_q, a_zero0_q;
  logic [CoefW-1:0]   a_mag0_q;

  assign a_mag = coef_i.coef_a[CoefW-1] ? (~coef_i.coef_a + 1'b1) : coef_i.coef_a;
  assign b_mag = coef_i.coef_b[CoefW-1] ? (~coef_i.coef_b + 1'b1) : coef_i.coef_b;
  assign c_mag = coef_i.coef_c[CoefW-1] ? (~coef_i.coef_c + 1'b1) : coef_i.coef_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    b2_q      <= b_mag * b_mag;
    ac_q      <= a_mag * c_mag;
    b0_q      <= coef_i.coef_b;
    neg_a0_q  <= coef_i.coef_a[CoefW-1];
    a_mag0_q  <= a_mag;
    a_zero0_q <= coef_i.coef_a == '0;
    ac_pos0_q <= (coef_i.coef_a[CoefW-1] == coef_i.coef_c[CoefW-1]) && (coef_i.coef_c != '0);
  end

  // discriminant and status
  logic [DiscW-1:0] p4, b2x, disc;
  status_e          st;
  logic             v1_q;
  logic [DiscW-1:0] rad1_q;
  tag_t             tag1_q;

  always_comb begin
    p4   = {ac_q, 2'b00};
    b2x  = {2'b00, b2_q};
    disc = '0;
    st   = ST_NONE;
    if (a_zero0_q) begin
      st = ST_AZERO;
    end else if (ac_pos0_q) begin
      if (p4 > b2x) begin
        st = ST_NONE;
      end else if (p4 == b2x) begin
        st = ST_DOUBLE;
      end else begin
        st   = ST_TWO;
        disc = b2x - p4;
      end
    end else begin
      disc = b2x + p4;
      st   = (disc == '0) ? ST_DOUBLE : ST_TWO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rad1_q        <= disc;
    tag1_q.b      <= b0_q;
    tag1_q.neg_a  <= neg_a0_q;
    tag1_q.den    <= {a_mag0_q, 1'b0};
    tag1_q.status <= st;
    tag1_q.sgn_p  <= 1'b0;
    tag1_q.sgn_m  <= 1'b0;
  end

  // square root row
  logic             sv   [0:SqrtW];
  tag_t             stag [0:SqrtW];
  logic [DiscW-1:0] srad [0:SqrtW];
  logic [RemW-1:0]  srem [0:SqrtW];
  logic [SqrtW-1:0] sroot[0:SqrtW];

  assign sv[0]    = v1_q;
  assign stag[0]  = tag1_q;
  assign srad[0]  = rad1_q;
  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar i = 0; i < SqrtW; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(sv[i]),
      .tag_i  (stag[i]),
      .rad_i  (srad[i]),
      .rem_i  (srem[i]),
      .root_i (sroot[i]),
      .valid_o(sv[i+1]),
      .tag_o  (stag[i+1]),
      .rad_o  (srad[i+1]),
      .rem_o  (srem[i+1]),
      .root_o (sroot[i+1])
    );
  end

  // numerators -b +/- s
  logic signed [MagW:0] nb, num_p, num_m;
  logic [MagW-1:0]      mag_p, mag_m;
  logic                 v2_q;
  tag_t                 tag2_q;
  logic [QuoW-1:0]      dvd_p2_q, dvd_m2_q;

  always_comb begin
    nb    = -(MagW+1)'(stag[SqrtW].b);
    num_p = nb + $signed({2'b00, sroot[SqrtW]});
    num_m = nb - $signed({2'b00, sroot[SqrtW]});
    mag_p = num_p[MagW] ? MagW'(-num_p) : num_p[MagW-1:0];
    mag_m = num_m[MagW] ? MagW'(-num_m) : num_m[MagW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= sv[SqrtW];
    end
  end

  always_ff @(posedge clk_i) begin
    tag2_q.b      <= stag[SqrtW].b;
    tag2_q.neg_a  <= stag[SqrtW].neg_a;
    tag2_q.den    <= stag[SqrtW].den;
    tag2_q.status <= stag[SqrtW].status;
    tag2_q.sgn_p  <= num_p[MagW] ^ stag[SqrtW].neg_a;
    tag2_q.sgn_m  <= num_m[MagW] ^ stag[SqrtW].neg_a;
    dvd_p2_q      <= {mag_p, 16'h0000};
    dvd_m2_q      <= {mag_m, 16'h0000};
  end

  // division row
  logic            dv    [0:QuoW];
  tag_t            dtag  [0:QuoW];
  logic [QuoW-1:0] ddvd_p[0:QuoW];
  logic [QuoW-1:0] ddvd_m[0:QuoW];
  logic [DenW-1:0] drem_p[0:QuoW];
  logic [DenW-1:0] drem_m[0:QuoW];
  logic [QuoW-1:0] dquo_p[0:QuoW];
  logic [QuoW-1:0] dquo_m[0:QuoW];

  assign dv[0]     = v2_q;
  assign dtag[0]   = tag2_q;
  assign ddvd_p[0] = dvd_p2_q;
  assign ddvd_m[0] = dvd_m2_q;
  assign drem_p[0] = '0;
  assign drem_m[0] = '0;
  assign dquo_p[0] = '0;
  assign dquo_m[0] = '0;

  for (genvar j = 0; j < QuoW; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(dv[j]),
      .tag_i  (dtag[j]),
      .dvd_p_i(ddvd_p[j]),
      .dvd_m_i(ddvd_m[j]),
      .rem_p_i(drem_p[j]),
      .rem_m_i(drem_m[j]),
      .quo_p_i(dquo_p[j]),
      .quo_m_i(dquo_m[j]),
      .valid_o(dv[j+1]),
      .tag_o  (dtag[j+1]),
      .dvd_p_o(ddvd_p[j+1]),
      .dvd_m_o(ddvd_m[j+1]),
      .rem_p_o(drem_p[j+1]),
      .rem_m_o(drem_m[j+1]),
      .quo_p_o(dquo_p[j+1]),
      .quo_m_o(dquo_m[j+1])
    );
  end

  // saturation and output register
  logic [RootW:0] sp, sm;
  logic           has_root;

  assign sp       = sat_root(dquo_p[QuoW], dtag[QuoW].sgn_p);
  assign sm       = sat_root(dquo_m[QuoW], dtag[QuoW].sgn_m);
  assign has_root = (dtag[QuoW].status == ST_DOUBLE) || (dtag[QuoW].status == ST_TWO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= dv[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    result_o.root_plus   <= has_root ? sp[RootW-1:0] : '0;
    result_o.root_minus  <= has_root ? sm[RootW-1:0] : '0;
    result_o.root_status <= dtag[QuoW].status;
    result_o.saturated   <= has_root & (sp[RootW] | sm[RootW]);
  end

  // every start beat yields a result beat marked by done_o at the end of the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##Latency done_o)
    else $error("result beat missing after start");

  // without a real root both roots and the flag are cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.root_status == ST_NONE || result_o.root_status == ST_AZERO)
    |-> result_o.root_plus == '0 && result_o.root_minus == '0 && !result_o.saturated)
    else $error("roots not cleared without real root");

  // a double root gives equal roots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.root_status == ST_DOUBLE
    |-> result_o.root_plus == result_o.root_minus)
    else $error("double root beat with unequal roots");

endmodule

@@ tb/quadratic_root_solver_tb.sv @@
// quadratic_root_solver_tb: self-checking bench for the quadratic root solver
// drives directed and random coefficient triples, predicts roots and status locally
// depends on qrs_pkg and quadratic_root_solver
`timescale 1ns / 100ps

module quadratic_root_solver_tb;
  import qrs_pkg::*;

  localparam int Latency = 55;

  logic  clk_i;
  logic  rst_ni;
  logic  start_i;
  logic  busy_o;
  coef_t coef_i;
  logic  done_o;
  root_t result_o;

  root_t roots_pending[$];
  int    n_bad;
  int    n_sent;
  bit    quiet_run;

  quadratic_root_solver dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .coef_i  (coef_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // floored square root of a value below 2^36
  function automatic logic [35:0] floor_sqrt(logic [35:0] d);
    logic [35:0] r;
    logic [35:0] trial;
    r = '0;
    for (int k = 17; k >= 0; k--) begin
      trial = r | (36'd1 << k);
      if (trial * trial <= d) r = trial;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] scaled_quot(longint num, longint den,
                                                     ref bit sat);
    longint q;
    q = (num * 65536) / den;
    if (q > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (q < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function automatic root_t solve_roots(coef_t t);
    root_t   r;
    longint  a, b, c, disc;
    logic [35:0] s;
    bit      sat;
    a = t.coef_a;
    b = t.coef_b;
    c = t.coef_c;
    sat = 1'b0;
    r = '0;
    if (a == 0) begin
      r.root_status = ST_AZERO;
    end else begin
      disc = b * b - 4 * a * c;
      if (disc < 0) begin
        r.root_status = ST_NONE;
      end else if (disc == 0) begin
        r.root_status = ST_DOUBLE;
        r.root_plus = scaled_quot(-b, 2 * a, sat);
        r.root_minus = r.root_plus;
      end else begin
        r.root_status = ST_TWO;
        s = floor_sqrt(disc[35:0]);
        r.root_plus = scaled_quot(-b + longint'(s), 2 * a, sat);
        r.root_minus = scaled_quot(-b - longint'(s), 2 * a, sat);
      end
    end
    r.saturated = sat;
    return r;
  endfunction

  // results cannot be held off: check every strobe
  always @(posedge clk_i) begin
    root_t want;
    if (rst_ni && done_o) begin
      if (roots_pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %p", result_o);
      end else begin
        want = roots_pending.pop_front();
        if (result_o.root_plus !== want.root_plus ||
            result_o.root_minus !== want.root_minus ||
            result_o.root_status !== want.root_status ||
            result_o.saturated !== want.saturated) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: expected %p, got %p", want, result_o);
        end
      end
    end
  end

  // one beat; hold start until accepted, optional idle cycles before
  task automatic send_triple(coef_t t, bit use_pred, root_t known);
    while (!quiet_run && $urandom_range(99) < 14) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    coef_i  <= t;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    roots_pending.push_back(use_pred ? solve_roots(t) : known);
    n_sent++;
    @(negedge clk_i);
  endtask

  typedef struct {
    coef_t t;
    bit    typed;
    root_t r;
  } row_t;

  function automatic coef_t mk(int a, int b, int c);
    coef_t t;
    t.coef_a = a[15:0];
    t.coef_b = b[15:0];
    t.coef_c = c[15:0];
    return t;
  endfunction

  function automatic root_t rs(int p, int m, status_e st, bit sat);
    root_t r;
    r.root_plus = p;
    r.root_minus = m;
    r.root_status = st;
    r.saturated = sat;
    return r;
  endfunction

  row_t  steer[$];
  coef_t t;
  int    mode;
  int    wait_cnt;

  initial begin
    n_bad = 0;
    n_sent = 0;
    quiet_run = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    coef_i = '0;
    // a is zero, nothing else looked at
    steer.push_back('{mk(0, 0, 0), 1, rs(0, 0, ST_AZERO, 0)});
    steer.push_back('{mk(0, 32767, -32768), 1, rs(0, 0, ST_AZERO, 0)});
    steer.push_back('{mk(0, -32768, 32767), 1, rs(0, 0, ST_AZERO, 0)});
    // negative discriminant
    steer.push_back('{mk(256, 0, 256), 1, rs(0, 0, ST_NONE, 0)});
    steer.push_back('{mk(-32768, 0, -32768), 1, rs(0, 0, ST_NONE, 0)});
    // double roots: b = 0, c = 0 and b^2 = 4ac, then an extreme triple with two roots
    steer.push_back('{mk(256, 0, 0), 1, rs(0, 0, ST_DOUBLE, 0)});
    steer.push_back('{mk(256, -512, 256), 1, rs(65536, 65536, ST_DOUBLE, 0)});
    steer.push_back('{mk(1, -32768, 32767), 0, '0});
    // two roots, x^2 - 1
    steer.push_back('{mk(256, 0, -256), 1, rs(65536, -65536, ST_TWO, 0)});
    // extremes, saturating ones among them
    steer.push_back('{mk(1, -32768, 0), 0, '0});
    steer.push_back('{mk(-1, 32767, 32767), 0, '0});
    steer.push_back('{mk(32767, 32767, -32768), 0, '0});
    steer.push_back('{mk(-32768, -32768, 32767), 0, '0});
    steer.push_back('{mk(-32768, -32768, -32768), 0, '0});
    steer.push_back('{mk(32767, 32767, 32767), 0, '0});
    steer.push_back('{mk(-1, -1, -1), 0, '0});
    steer.push_back('{mk(1, 1, -1), 0, '0});
    steer.push_back('{mk(-32768, 32767, 32767), 0, '0});
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (steer[i]) send_triple(steer[i].t, !steer[i].typed, steer[i].r);
    for (int i = 0; i < 2000; i++) begin
      quiet_run = (i >= 800 && i < 1100);
      mode = $urandom_range(9);
      t = coef_t'(48'({$urandom, $urandom}));
      case (mode)
        0: begin
          t.coef_a = 16'($urandom_range(15)) - 16'd8;
          t.coef_b = 16'($urandom);
        end
        1: begin
          t.coef_a = '0;
        end
        2: begin
          // forced double root, or a zero when b = 0: a = c = b/2 gives b^2 = 4ac
          t.coef_b = 16'($urandom_range(255)) * 16'd2 - 16'd256;
          t.coef_a = t.coef_b >>> 1;
          t.coef_c = t.coef_b >>> 1;
        end
        3: begin
          t.coef_a = 16'($urandom_range(511)) - 16'd256;
          t.coef_b = 16'($urandom_range(511)) - 16'd256;
          t.coef_c = 16'($urandom_range(511)) - 16'd256;
        end
        default: ;
      endcase
      send_triple(t, 1'b1, '0);
    end
    start_i <= 1'b0;
    wait_cnt = 0;
    while (roots_pending.size() != 0 && wait_cnt < 10000) begin
      @(negedge clk_i);
      wait_cnt++;
    end
    repeat (Latency + 10) @(negedge clk_i);
    if (n_bad == 0 && roots_pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
